/* hw/rtl/uvs_pkg.sv */
package uvs_pkg;

  localparam int IDX_W      = 11;
  localparam int RAD_W      = 16;
  localparam int POS_W      = 17;
  localparam int NRM_W      = 16;
  localparam int TEX_W      = 17;
  localparam int VNUM_W     = 21;
  localparam int FRAC_W     = 17;
  localparam int NUM_W      = IDX_W + 17;
  localparam int ANG_W      = 25;
  localparam int CRD_W      = 32;
  localparam int T_W        = 33;
  localparam int STEPS      = 16;
  localparam int MAX_DIV_DEF = 1024;

  localparam logic signed [CRD_W-1:0] CORDIC_GAIN = 32'sd652032874;

  typedef enum logic [1:0] {
    REG_RADIUS = 2'd0,
    REG_STACK  = 2'd1,
    REG_SLICE  = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [TEX_W-1:0]  tex_u;
    logic [TEX_W-1:0]  tex_v;
    logic [VNUM_W-1:0] vnum;
  } side_t;

  function automatic logic signed [ANG_W-1:0] atan_lut(input int k);
    case (k)
      0:  atan_lut = 25'sd4194304;
      1:  atan_lut = 25'sd2476042;
      2:  atan_lut = 25'sd1308273;
      3:  atan_lut = 25'sd664100;
      4:  atan_lut = 25'sd333339;
      5:  atan_lut = 25'sd166832;
      6:  atan_lut = 25'sd83436;
      7:  atan_lut = 25'sd41721;
      8:  atan_lut = 25'sd20861;
      9:  atan_lut = 25'sd10430;
      10: atan_lut = 25'sd5215;
      11: atan_lut = 25'sd2608;
      12: atan_lut = 25'sd1304;
      13: atan_lut = 25'sd652;
      14: atan_lut = 25'sd326;
      15: atan_lut = 25'sd163;
      default: atan_lut = '0;
    endcase
  endfunction

endpackage

/* hw/rtl/uv_sphere_vertex_generator.sv */
// Throughput: one item per cycle; the whole pipeline holds while the
// output is stalled, so one item per clock whenever m_axis_tready is high.
// Depth is set by two 17-step restoring dividers and two 16-step CORDICs.
// Reset (rst, synchronous): pipeline empties; radius 256, stacks 16, slices 32.
module uv_sphere_vertex_generator
  import uvs_pkg::*;
#(
  parameter int MAX_DIVISIONS = MAX_DIV_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // stack_index[10:0], slice_index[21:11], zero[23:22]
  input  logic [23:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // pos_x[16:0], pos_y[33:17], pos_z[50:34], normal_x[66:51], normal_y[82:67],
  // normal_z[98:83], tex_u[115:99], tex_v[132:116], vertex_number[153:133], zero
  output logic [159:0] m_axis_tdata,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_addr,
  input  logic [15:0]  cfg_wdata
);

  localparam int NSTG = 40;
  localparam int DIV0 = 0;
  localparam int CRD0 = DIV0 + FRAC_W + 1;
  localparam int NSIDE = NSTG - CRD0;
  localparam logic [IDX_W+1:0] MAX_C = (IDX_W+2)'(MAX_DIVISIONS);

  logic [RAD_W-1:0] radius;
  logic [IDX_W-1:0] stack_count;
  logic [IDX_W-1:0] slice_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius      <= RAD_W'(256);
      stack_count <= IDX_W'(16);
      slice_count <= IDX_W'(32);
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_RADIUS: radius      <= cfg_wdata;
        REG_STACK:  stack_count <= cfg_wdata[IDX_W-1:0];
        REG_SLICE:  slice_count <= cfg_wdata[IDX_W-1:0];
        default: ;
      endcase
    end
  end

  function automatic logic [IDX_W-1:0] eff(input logic [IDX_W-1:0] c);
    if (c == '0) eff = IDX_W'(1);
    else if ({2'b00, c} > MAX_C) eff = MAX_C[IDX_W-1:0];
    else eff = c;
  endfunction

  logic [NSTG-1:0] vld;
  logic en;
  assign en = !vld[NSTG-1] || m_axis_tready;
  assign s_axis_tready = en && !rst;
  assign m_axis_tvalid = vld[NSTG-1];

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[NSTG-2:0], s_axis_tvalid};
  end

  // stage 0: saturate, numerators, vertex number
  logic [IDX_W-1:0]  sc_e, lc_e, i_s, j_s;
  logic [IDX_W-1:0]  in_i, in_j;
  logic [23:0]       vprod;
  assign in_i = s_axis_tdata[10:0];
  assign in_j = s_axis_tdata[21:11];

  always_comb begin
    sc_e  = eff(stack_count);
    lc_e  = eff(slice_count);
    i_s   = (in_i > sc_e) ? sc_e : in_i;
    j_s   = (in_j > lc_e) ? lc_e : in_j;
    vprod = ({13'b0, i_s} * {12'b0, {1'b0, lc_e} + 12'd1}) + {13'b0, j_s};
  end

  logic [NUM_W-1:0]  rv [FRAC_W+1];
  logic [NUM_W-1:0]  ru [FRAC_W+1];
  logic [FRAC_W-1:0] qv [FRAC_W+1];
  logic [FRAC_W-1:0] qu [FRAC_W+1];
  logic [IDX_W-1:0]  dv [FRAC_W+1];
  logic [IDX_W-1:0]  du [FRAC_W+1];
  logic [VNUM_W-1:0] vn [FRAC_W+1];

  always_ff @(posedge clk) begin
    if (en) begin
      rv[0] <= (NUM_W'(i_s) << 16) + NUM_W'(sc_e >> 1);
      ru[0] <= (NUM_W'(j_s) << 16) + NUM_W'(lc_e >> 1);
      qv[0] <= '0;
      qu[0] <= '0;
      dv[0] <= sc_e;
      du[0] <= lc_e;
      vn[0] <= vprod[VNUM_W-1:0];
      for (int s = 1; s <= FRAC_W; s++) begin
        if (rv[s-1] >= (NUM_W'(dv[s-1]) << (FRAC_W - s))) begin
          rv[s] <= rv[s-1] - (NUM_W'(dv[s-1]) << (FRAC_W - s));
          qv[s] <= qv[s-1] | (FRAC_W'(1) << (FRAC_W - s));
        end else begin
          rv[s] <= rv[s-1];
          qv[s] <= qv[s-1];
        end
        if (ru[s-1] >= (NUM_W'(du[s-1]) << (FRAC_W - s))) begin
          ru[s] <= ru[s-1] - (NUM_W'(du[s-1]) << (FRAC_W - s));
          qu[s] <= qu[s-1] | (FRAC_W'(1) << (FRAC_W - s));
        end else begin
          ru[s] <= ru[s-1];
          qu[s] <= qu[s-1];
        end
        dv[s] <= dv[s-1];
        du[s] <= du[s-1];
        vn[s] <= vn[s-1];
      end
    end
  end

  // side data delay line, index 0 at CORDIC setup
  side_t side [NSIDE];
  always_ff @(posedge clk) begin
    if (en) begin
      side[0] <= '{tex_u: qu[FRAC_W], tex_v: qv[FRAC_W], vnum: vn[FRAC_W]};
      for (int s = 1; s < NSIDE; s++) side[s] <= side[s-1];
    end
  end

  // CORDIC, phi (p) and theta (t) side by side
  logic signed [CRD_W-1:0] xp [STEPS+1];
  logic signed [CRD_W-1:0] yp [STEPS+1];
  logic signed [ANG_W-1:0] zp [STEPS+1];
  logic signed [CRD_W-1:0] xt [STEPS+1];
  logic signed [CRD_W-1:0] yt [STEPS+1];
  logic signed [ANG_W-1:0] zt [STEPS+1];
  logic [1:0]              qdp [STEPS+1];
  logic [1:0]              qdt [STEPS+1];
  logic [FRAC_W-1:0]       ph_p, ph_t;

  assign ph_p = qv[FRAC_W];
  assign ph_t = {qu[FRAC_W][FRAC_W-2:0], 1'b0};

  always_ff @(posedge clk) begin
    if (en) begin
      xp[0]  <= CORDIC_GAIN;
      yp[0]  <= '0;
      zp[0]  <= $signed({2'b00, ph_p[14:0], 8'b0});
      qdp[0] <= ph_p[16:15];
      xt[0]  <= CORDIC_GAIN;
      yt[0]  <= '0;
      zt[0]  <= $signed({2'b00, ph_t[14:0], 8'b0});
      qdt[0] <= ph_t[16:15];
      for (int k = 0; k < STEPS; k++) begin
        if (zp[k] >= 0) begin
          xp[k+1] <= xp[k] - (yp[k] >>> k);
          yp[k+1] <= yp[k] + (xp[k] >>> k);
          zp[k+1] <= zp[k] - atan_lut(k);
        end else begin
          xp[k+1] <= xp[k] + (yp[k] >>> k);
          yp[k+1] <= yp[k] - (xp[k] >>> k);
          zp[k+1] <= zp[k] + atan_lut(k);
        end
        if (zt[k] >= 0) begin
          xt[k+1] <= xt[k] - (yt[k] >>> k);
          yt[k+1] <= yt[k] + (xt[k] >>> k);
          zt[k+1] <= zt[k] - atan_lut(k);
        end else begin
          xt[k+1] <= xt[k] + (yt[k] >>> k);
          yt[k+1] <= yt[k] - (xt[k] >>> k);
          zt[k+1] <= zt[k] + atan_lut(k);
        end
        qdp[k+1] <= qdp[k];
        qdt[k+1] <= qdt[k];
      end
    end
  end

  // quadrant map
  logic signed [CRD_W-1:0] cp, sp, ct, st;
  always_ff @(posedge clk) begin
    if (en) begin
      case (qdp[STEPS])
        2'd0:    begin cp <= xp[STEPS];  sp <= yp[STEPS];  end
        2'd1:    begin cp <= -yp[STEPS]; sp <= xp[STEPS];  end
        2'd2:    begin cp <= -xp[STEPS]; sp <= -yp[STEPS]; end
        default: begin cp <= yp[STEPS];  sp <= -xp[STEPS]; end
      endcase
      case (qdt[STEPS])
        2'd0:    begin ct <= xt[STEPS];  st <= yt[STEPS];  end
        2'd1:    begin ct <= -yt[STEPS]; st <= xt[STEPS];  end
        2'd2:    begin ct <= -xt[STEPS]; st <= -yt[STEPS]; end
        default: begin ct <= yt[STEPS];  st <= -xt[STEPS]; end
      endcase
    end
  end

  // products, unit terms, scaling
  logic signed [2*CRD_W-1:0] prx, prz;
  logic signed [CRD_W-1:0]   cp1;
  logic signed [NRM_W-1:0]   nx2, ny2, nz2, nx3, ny3, nz3;
  logic signed [POS_W-1:0]   px3, py3, pz3;
  logic signed [2*CRD_W-1:0] prx_r, prz_r;
  logic signed [T_W-1:0]     tx_r, ty_r, tz_r;
  logic signed [2*CRD_W-1:0] rx_r, ry_r, rz_r;

  function automatic logic signed [NRM_W-1:0] nsat(input logic signed [T_W-1:0] t);
    logic signed [T_W-1:0] r;
    r = (t + T_W'(32768)) >>> 16;
    if (r > T_W'(16384)) nsat = NRM_W'(16384);
    else if (r < -T_W'(16384)) nsat = -NRM_W'(16384);
    else nsat = r[NRM_W-1:0];
  endfunction

  function automatic logic signed [POS_W-1:0] psat(input logic signed [2*CRD_W-1:0] p);
    logic signed [2*CRD_W-1:0] r;
    r = (p + (64'sd1 <<< 29)) >>> 30;
    if (r > 64'sd65535) psat = POS_W'(65535);
    else if (r < -64'sd65535) psat = -POS_W'(65535);
    else psat = r[POS_W-1:0];
  endfunction

  assign prx_r = (prx + (64'sd1 <<< 29)) >>> 30;
  assign prz_r = (prz + (64'sd1 <<< 29)) >>> 30;

  always_ff @(posedge clk) begin
    if (en) begin
      prx  <= sp * ct;
      prz  <= sp * st;
      cp1  <= cp;
      tx_r <= prx_r[T_W-1:0];
      ty_r <= T_W'(cp1);
      tz_r <= prz_r[T_W-1:0];
      rx_r <= $signed({{(2*CRD_W-RAD_W){1'b0}}, radius}) * 64'(tx_r);
      ry_r <= $signed({{(2*CRD_W-RAD_W){1'b0}}, radius}) * 64'(ty_r);
      rz_r <= $signed({{(2*CRD_W-RAD_W){1'b0}}, radius}) * 64'(tz_r);
      nx2  <= nsat(tx_r);
      ny2  <= nsat(ty_r);
      nz2  <= nsat(tz_r);
      px3  <= psat(rx_r);
      py3  <= psat(ry_r);
      pz3  <= psat(rz_r);
      nx3  <= nx2;
      ny3  <= ny2;
      nz3  <= nz2;
    end
  end

  side_t so;
  assign so = side[NSIDE-1];
  assign m_axis_tdata = {6'b0, so.vnum, so.tex_v, so.tex_u, nz3, ny3, nx3, pz3, py3, px3};

  ast_accept_enters: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> vld[0])
    else $error("accepted item not in first stage");

  ast_tex_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (so.tex_u <= TEX_W'(65536) && so.tex_v <= TEX_W'(65536)))
    else $error("texture coordinate above one");

  ast_normal_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (nx3 <= 16'sd16384 && nx3 >= -16'sd16384 &&
                       ny3 <= 16'sd16384 && ny3 >= -16'sd16384))
    else $error("normal out of range");

  ast_hold: assert property (@(posedge clk) disable iff (rst)
    (!en) |=> $stable(vld))
    else $error("pipeline moved while stalled");

endmodule
